// ===== src/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants for the queue load scoring block.
// ----------------------------------------------------------------------------
package clm_pkg;

    localparam int NUM_W   = 47;   // value * 25600 for a 32-bit value
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 15;   // every quotient is below 25600
    localparam int SUM_W   = 17;   // four quotients summed
    localparam int DIV_LAT = QUO_W;

    // Reciprocal of three for sums below 2^17: floor(s * RECIP3 >> 18)
    localparam logic [17:0] RECIP3  = 18'd87382;
    localparam int          RECIP_SH = 18;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd0;
    localparam logic [1:0] REG_VOLUME_LIMIT = 2'd1;
    localparam logic [1:0] REG_AGE_LIMIT   = 2'd2;
    localparam logic [1:0] REG_IDLE_LIMIT  = 2'd3;

    // Factor lanes
    localparam int F_COUNT = 0;
    localparam int F_VOL   = 1;
    localparam int F_AGE   = 2;
    localparam int F_IDLE  = 3;

    typedef struct packed {
        logic       at_max;
        logic [3:0] counted;
    } t_flags;

endpackage

// ===== src/clm_if.sv =====
// ----------------------------------------------------------------------------
// clm_in_if / clm_out_if
// Valid/ready channels carrying one queue measure and one load score.
// ----------------------------------------------------------------------------
interface clm_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] message_count;
    logic [23:0] report_count;
    logic [31:0] queued_volume;
    logic [31:0] oldest_time;
    logic [31:0] success_time;
    logic [31:0] now_time;

    modport source (output valid, message_count, report_count, queued_volume,
                    oldest_time, success_time, now_time, input ready);
    modport sink   (input valid, message_count, report_count, queued_volume,
                    oldest_time, success_time, now_time, output ready);
endinterface

interface clm_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] load_score;
    logic        at_maximum;

    modport source (output valid, load_score, at_maximum, input ready);
    modport sink   (input valid, load_score, at_maximum, output ready);
endinterface

// ===== src/clm_divider.sv =====
// ----------------------------------------------------------------------------
// clm_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module clm_divider (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [clm_pkg::NUM_W-1:0]  i_num,
    input  logic [clm_pkg::DEN_W-1:0]  i_den,
    output logic [clm_pkg::QUO_W-1:0]  o_quo
);

    localparam int NW = clm_pkg::NUM_W;
    localparam int DW = clm_pkg::DEN_W;
    localparam int QW = clm_pkg::QUO_W;

    logic [DW-1:0] w_rem [0:QW];
    logic [QW-1:0] w_low [0:QW];
    logic [QW-1:0] w_q   [0:QW];

    assign w_rem[0] = i_num[NW-1:QW];
    assign w_low[0] = i_num[QW-1:0];
    assign w_q[0]   = '0;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   n_shift;
        logic          n_fit;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_low;
        logic [QW-1:0] r_q;

        always_comb begin
            n_shift = {w_rem[k], w_low[k][QW-1]};
            n_fit   = (n_shift >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_fit ? DW'(n_shift - {1'b0, i_den}) : n_shift[DW-1:0];
                r_low <= {w_low[k][QW-2:0], 1'b0};
                r_q   <= {w_q[k][QW-2:0], n_fit};
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_low[k+1] = r_low;
        assign w_q[k+1]   = r_q;
    end

    assign o_quo = w_q[QW];

endmodule

// ===== src/channel_load_measure.sv =====
// ----------------------------------------------------------------------------
// channel_load_measure
// Queue load score, four configured bounds, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one queue measure per beat (counts, volume, timestamps);
//   o_out returns one beat per input beat, in order: load_score in percent
//   with 8 fractional bits and at_maximum when an enabled bound is reached.
//   The bounds are written over the APB-style port while no beat is in
//   flight; a bound of zero disables its factor.
// Depth: 20 register stages (2 front, 15 divider, 3 tail); the result
//   lands in the output register, the last of them.
// Throughput: one beat per cycle while not stalled; the 15-stage restoring
//   dividers, one quotient bit per stage and one per factor, set the depth.
// Reset: i_rst_n clears all valid bits and the four bounds (all disabled).
// Stall: when the receiver holds ready low with a result waiting, the
//   whole pipeline freezes and i_in.ready drops; nothing is lost or
//   repeated. Bubbles drain while the output register is empty.
// ----------------------------------------------------------------------------
module channel_load_measure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clm_in_if.sink      i_in,
    clm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = clm_pkg::NUM_W;
    localparam int DL = clm_pkg::DIV_LAT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0] r_count_limit;
    logic [31:0] r_volume_limit;
    logic [15:0] r_age_limit;
    logic [15:0] r_idle_limit;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit  <= '0;
            r_volume_limit <= '0;
            r_age_limit    <= '0;
            r_idle_limit   <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                clm_pkg::REG_COUNT_LIMIT:  r_count_limit  <= pwdata[23:0];
                clm_pkg::REG_VOLUME_LIMIT: r_volume_limit <= pwdata;
                clm_pkg::REG_AGE_LIMIT:    r_age_limit    <= pwdata[15:0];
                clm_pkg::REG_IDLE_LIMIT:   r_idle_limit   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            clm_pkg::REG_COUNT_LIMIT:  prdata = {8'd0, r_count_limit};
            clm_pkg::REG_VOLUME_LIMIT: prdata = r_volume_limit;
            clm_pkg::REG_AGE_LIMIT:    prdata = {16'd0, r_age_limit};
            clm_pkg::REG_IDLE_LIMIT:   prdata = {16'd0, r_idle_limit};
            default:                   prdata = '0;
        endcase
    end

    // Age bounds in seconds: minutes * 60 = (m << 6) - (m << 2)
    logic [21:0] w_age_span;
    logic [21:0] w_idle_span;
    assign w_age_span  = {r_age_limit, 6'd0}  - {4'd0, r_age_limit, 2'd0};
    assign w_idle_span = {r_idle_limit, 6'd0} - {4'd0, r_idle_limit, 2'd0};

    // ------------------------------------------------------------------
    // Global advance: move every stage unless a result is held
    // ------------------------------------------------------------------
    logic w_en;
    logic r_e_valid;

    assign w_en       = !r_e_valid || o_out.ready;
    assign i_in.ready = w_en;

    // ------------------------------------------------------------------
    // Stage A: item count and elapsed times
    // ------------------------------------------------------------------
    logic        r_a_valid;
    logic [24:0] r_a_items;
    logic [31:0] r_a_vol;
    logic [31:0] r_a_age;
    logic [31:0] r_a_idle;
    logic        w_has_items;

    assign w_has_items = (i_in.message_count != '0) || (i_in.report_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_items <= {1'b0, i_in.message_count} + {1'b0, i_in.report_count};
            r_a_vol   <= i_in.queued_volume;
            // Saturate negative elapsed time to zero
            if (i_in.oldest_time != '0 && w_has_items && i_in.now_time >= i_in.oldest_time)
                r_a_age <= i_in.now_time - i_in.oldest_time;
            else
                r_a_age <= '0;
            if (i_in.success_time != '0 && i_in.now_time >= i_in.success_time)
                r_a_idle <= i_in.now_time - i_in.success_time;
            else
                r_a_idle <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: bound checks, factor selection and numerators (v * 25600)
    // ------------------------------------------------------------------
    clm_pkg::t_flags w_b_flags;
    logic            w_cnt_max, w_vol_max, w_age_max, w_idle_max, w_idle_half;
    logic            r_b_valid;
    clm_pkg::t_flags r_b_flags;
    logic [NW-1:0]   r_b_num [0:3];

    function automatic logic [NW-1:0] scale_pct(input logic [31:0] v);
        logic [36:0] t;
        begin
            // v * 25 = (v << 4) + (v << 3) + v, then << 10
            t = {1'b0, v, 4'd0} + {2'd0, v, 3'd0} + {5'd0, v};
            scale_pct = {t, 10'd0};
        end
    endfunction

    always_comb begin
        w_cnt_max   = (r_count_limit != '0) && (r_a_items >= {1'b0, r_count_limit});
        w_vol_max   = (r_volume_limit != '0) && (r_a_vol >= r_volume_limit);
        w_age_max   = (r_age_limit != '0) && (r_a_age >= {10'd0, w_age_span});
        w_idle_max  = (r_idle_limit != '0) && (r_a_idle >= {10'd0, w_idle_span});
        w_idle_half = ({r_a_idle, 1'b0} >= {11'd0, w_idle_span});
        w_b_flags.at_max = w_cnt_max | w_vol_max | w_age_max | w_idle_max;
        w_b_flags.counted[clm_pkg::F_COUNT] = (r_count_limit != '0);
        w_b_flags.counted[clm_pkg::F_VOL]   = (r_volume_limit != '0);
        w_b_flags.counted[clm_pkg::F_AGE]   = (r_age_limit != '0);
        w_b_flags.counted[clm_pkg::F_IDLE]  = (r_idle_limit != '0) && w_idle_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_flags  <= w_b_flags;
            r_b_num[0] <= scale_pct({7'd0, r_a_items});
            r_b_num[1] <= scale_pct(r_a_vol);
            r_b_num[2] <= scale_pct(r_a_age);
            r_b_num[3] <= scale_pct(r_a_idle);
        end
    end

    // ------------------------------------------------------------------
    // Divider lanes, with valid and flags carried alongside
    // ------------------------------------------------------------------
    logic [clm_pkg::DEN_W-1:0] w_den [0:3];
    logic [clm_pkg::QUO_W-1:0] w_quo [0:3];

    assign w_den[0] = {8'd0, r_count_limit};
    assign w_den[1] = r_volume_limit;
    assign w_den[2] = {10'd0, w_age_span};
    assign w_den[3] = {10'd0, w_idle_span};

    for (genvar f = 0; f < 4; f++) begin : g_lane
        clm_divider u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_b_num[f]),
            .i_den (w_den[f]),
            .o_quo (w_quo[f])
        );
    end

    logic [DL-1:0]   r_dv_valid;
    clm_pkg::t_flags r_dv_flags [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid <= '0;
        end else if (w_en) begin
            r_dv_valid <= {r_dv_valid[DL-2:0], r_b_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_flags[0] <= r_b_flags;
            for (int k = 1; k < DL; k++) begin
                r_dv_flags[k] <= r_dv_flags[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sum counted quotients and count factors
    // ------------------------------------------------------------------
    clm_pkg::t_flags           w_fl;
    logic [clm_pkg::SUM_W-1:0] w_sum;
    logic [2:0]                w_nfac;
    logic                      r_c_valid;
    logic                      r_c_max;
    logic [clm_pkg::SUM_W-1:0] r_c_sum;
    logic [2:0]                r_c_nfac;

    always_comb begin
        w_fl   = r_dv_flags[DL-1];
        w_sum  = '0;
        w_nfac = '0;
        for (int f = 0; f < 4; f++) begin
            if (w_fl.counted[f]) begin
                w_sum  = w_sum + {2'd0, w_quo[f]};
                w_nfac = w_nfac + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_dv_valid[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_max  <= w_fl.at_max;
            r_c_sum  <= w_sum;
            r_c_nfac <= w_nfac;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: reciprocal product for division by three
    // ------------------------------------------------------------------
    logic                      r_d_valid;
    logic                      r_d_max;
    logic [clm_pkg::SUM_W-1:0] r_d_sum;
    logic [2:0]                r_d_nfac;
    logic [34:0]               r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_max  <= r_c_max;
            r_d_sum  <= r_c_sum;
            r_d_nfac <= r_c_nfac;
            r_d_prod <= 35'(r_c_sum) * 35'(clm_pkg::RECIP3);
        end
    end

    // ------------------------------------------------------------------
    // Stage E: average select, output register
    // ------------------------------------------------------------------
    logic [clm_pkg::SUM_W-1:0] w_avg;
    logic [14:0]               r_e_score;
    logic                      r_e_max;

    always_comb begin
        case (r_d_nfac)
            3'd2:    w_avg = r_d_sum >> 1;
            3'd3:    w_avg = r_d_prod[clm_pkg::RECIP_SH +: clm_pkg::SUM_W];
            3'd4:    w_avg = r_d_sum >> 2;
            default: w_avg = r_d_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_max   <= r_d_max;
            r_e_score <= r_d_max ? 15'd0 : w_avg[14:0];
        end
    end

    assign o_out.valid      = r_e_valid;
    assign o_out.load_score = r_e_score;
    assign o_out.at_maximum = r_e_max;

endmodule
